// ===== design/rwr_pkg.sv =====
// Package for the reorder window receiver.
// Holds window sizing, stage and status codes, and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package rwr_pkg;

  localparam int WINDOW_SLOTS = 64;
  localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
  localparam int TGT_W        = SLOT_W + 1;
  localparam int DESC_W       = 27;

  localparam logic [10:0] MAX_PAYLOAD = 11'd1460;
  localparam logic [2:0]  STAGE_FIN   = 3'd4;

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_DUP    = 2'd1,
    ST_OUTWIN = 2'd2,
    ST_FIN    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_WALK  = 3'b100
  } state_t;

  typedef struct packed {
    logic load_in;
    logic emit_status;
    logic store;
    logic emit_first;
    logic emit_walk;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_order;
    logic store_ok;
    logic next_empty;
  } sts_t;

endpackage

// ===== design/reorder_window_receiver_unit.sv =====
// Top level of the reorder window receiver.
// Instantiates rwr_ctrl and rwr_datapath; depends on rwr_pkg.
//
//  channel | dir | tdata (low bit up)                         | tuser                | tlast
//  in_     | in  | seq_number, payload_bytes, payload_handle  | stage_code           | -
//  out_    | out | release_handle, release_bytes, ack_number  | release_valid,status | last_of_run
//
// An input word is accepted in S_IDLE and classified in S_CHECK when the output register is free.
// An in-order word then releases one stored slot per cycle, while out_ is not stalled, from the
// descriptor memory's registered read port until the next slot is empty.
// A stall on out_ holds the controller; in_tready is high only between words.
// Synchronous active-low reset clears the expected number and all slot valid bits.
`timescale 1ns / 1ps

module reorder_window_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // seq_number[31:0], payload_bytes[42:32], payload_handle[58:43]
  input  logic [2:0]  in_tuser,    // stage_code[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // release_handle[15:0], release_bytes[26:16], ack_number[58:27]
  output logic [2:0]  out_tuser,   // release_valid[0], status_code[2:1]
  output logic        out_tlast
);
  import rwr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rwr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rwr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/rwr_ctrl.sv =====
// Controller state machine for the reorder window receiver.
// Sequences accept, classify and in-order release walk; depends on rwr_pkg.
`timescale 1ns / 1ps

module rwr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  rwr_pkg::sts_t sts,
  output rwr_pkg::cmd_t cmd
);
  import rwr_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.out_free) begin
          if (sts.in_order) begin
            cmd.emit_first = 1'b1;
            state_nxt      = sts.next_empty ? S_IDLE : S_WALK;
          end else begin
            cmd.emit_status = 1'b1;
            cmd.store       = sts.store_ok;
            state_nxt       = S_IDLE;
          end
        end
      end
      S_WALK: begin
        if (sts.out_free) begin
          cmd.emit_walk = 1'b1;
          if (sts.next_empty) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_single_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_status, cmd.emit_first, cmd.emit_walk}))
    else $error("more than one emit command");

  a_store_with_status: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> cmd.emit_status)
    else $error("store without status result");

  a_walk_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> $past(cmd.emit_first) || $past(cmd.emit_walk)
                            || $past(state_r == S_WALK))
    else $error("walk entered without a release");

endmodule

// ===== design/rwr_datapath.sv =====
// Datapath for the reorder window receiver: input word, expected number,
// slot valid bits, descriptor memory and output register. Depends on rwr_pkg.
`timescale 1ns / 1ps

module rwr_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [63:0]   in_tdata,    // seq_number, payload_bytes, payload_handle
  input  logic [2:0]    in_tuser,    // stage_code
  input  rwr_pkg::cmd_t cmd,
  output rwr_pkg::sts_t sts,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,   // release_handle, release_bytes, ack_number
  output logic [2:0]    out_tuser,   // release_valid, status_code
  output logic          out_tlast
);
  import rwr_pkg::*;

  logic [2:0]        stage_r;
  logic [31:0]       seq_r;
  logic [10:0]       bytes_r;
  logic [15:0]       handle_r;
  logic [31:0]       exp_r;
  logic [SLOT_W-1:0] slot_r;
  logic [WINDOW_SLOTS-1:0] filled_r;
  logic [DESC_W-1:0] mem [WINDOW_SLOTS];
  logic [DESC_W-1:0] mem_q_r;

  logic              ov_r;
  logic              o_rv_r;
  logic [15:0]       o_handle_r;
  logic [10:0]       o_bytes_r;
  logic [31:0]       o_ack_r;
  status_t           o_stat_r;
  logic              o_last_r;

  logic [10:0]       in_bytes_sat;
  logic [31:0]       diff;
  logic              is_fin, behind, outwin, taken;
  logic [TGT_W-1:0]  tgt_sum;
  logic [SLOT_W-1:0] tgt_slot;
  logic [SLOT_W-1:0] next_slot;
  logic [SLOT_W-1:0] rd_addr;
  logic              advance;
  logic              emit;
  status_t           stat;

  assign in_bytes_sat = (in_tdata[42:32] > MAX_PAYLOAD) ? MAX_PAYLOAD : in_tdata[42:32];

  assign diff    = seq_r - exp_r;
  assign is_fin  = (stage_r == STAGE_FIN);
  assign behind  = (seq_r < exp_r);
  assign outwin  = (diff >= 32'(WINDOW_SLOTS));
  assign tgt_sum = {1'b0, slot_r} + {1'b0, diff[SLOT_W-1:0]};
  assign tgt_slot = (tgt_sum >= TGT_W'(WINDOW_SLOTS))
                    ? SLOT_W'(tgt_sum - TGT_W'(WINDOW_SLOTS)) : tgt_sum[SLOT_W-1:0];
  assign taken   = filled_r[tgt_slot];
  assign next_slot = (slot_r == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 : slot_r + SLOT_W'(1);

  always_comb begin
    if (is_fin) begin
      stat = ST_FIN;
    end else if (behind) begin
      stat = ST_DUP;
    end else if (outwin) begin
      stat = ST_OUTWIN;
    end else if (taken) begin
      stat = ST_DUP;
    end else begin
      stat = ST_STORED;
    end
  end

  assign advance = cmd.emit_first | cmd.emit_walk;
  assign emit    = advance | cmd.emit_status;
  assign rd_addr = advance ? next_slot : slot_r;

  assign sts.out_free   = !ov_r || out_tready;
  assign sts.in_order   = !is_fin && !behind && !outwin && (diff == 32'd0);
  assign sts.store_ok   = !is_fin && !behind && !outwin && !taken && (diff != 32'd0);
  assign sts.next_empty = !filled_r[next_slot];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      stage_r  <= in_tuser;
      seq_r    <= in_tdata[31:0];
      bytes_r  <= in_bytes_sat;
      handle_r <= in_tdata[58:43];
    end
    if (cmd.store) begin
      mem[tgt_slot] <= {handle_r, bytes_r};
    end
    mem_q_r <= mem[rd_addr];
    if (emit) begin
      o_rv_r   <= advance;
      o_ack_r  <= advance ? exp_r : exp_r - 32'd1;
      o_stat_r <= advance ? ST_STORED : stat;
      o_last_r <= advance ? sts.next_empty : 1'b1;
      case (1'b1)
        cmd.emit_first: begin
          o_handle_r <= handle_r;
          o_bytes_r  <= bytes_r;
        end
        cmd.emit_walk: begin
          o_handle_r <= mem_q_r[26:11];
          o_bytes_r  <= mem_q_r[10:0];
        end
        default: begin
          o_handle_r <= '0;
          o_bytes_r  <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r    <= '0;
      slot_r   <= '0;
      filled_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (advance) begin
        exp_r  <= exp_r + 32'd1;
        slot_r <= next_slot;
      end
      if (cmd.store) begin
        filled_r[tgt_slot] <= 1'b1;
      end
      if (cmd.emit_walk) begin
        filled_r[slot_r] <= 1'b0;
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, o_ack_r, o_bytes_r, o_handle_r};
  assign out_tuser  = {o_stat_r, o_rv_r};
  assign out_tlast  = o_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!ov_r || out_tready))
    else $error("result word overwritten");

  a_store_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> !filled_r[tgt_slot])
    else $error("store into filled slot");

  a_walk_filled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_walk |-> filled_r[slot_r])
    else $error("release of empty slot");

  a_slot_tracks_seq: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (exp_r == $past(exp_r) + 32'd1) && (slot_r != $past(slot_r)))
    else $error("expected number and slot out of step");

endmodule

// ===== test/tb_reorder_window_receiver_unit.sv =====
// Testbench for reorder_window_receiver_unit: directed and random packet words,
// checked against an in-bench model of the reorder window and in-order release.
// Depends on rwr_pkg and the RTL under design/.
`timescale 1ns / 1ps

module tb_reorder_window_receiver_unit;
  import rwr_pkg::*;

  typedef struct {
    logic [2:0]  stage;
    logic [31:0] seq;
    logic [10:0] bytes;
    logic [15:0] handle;
    bit          hold_for_drain;
  } packet_t;

  typedef struct {
    logic        rel_valid;
    logic [15:0] handle;
    logic [10:0] bytes;
    logic [31:0] ack;
    status_t     status;
    logic        last;
  } ack_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  reorder_window_receiver_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // window model
  logic [31:0]       next_seq;
  bit                slot_full [WINDOW_SLOTS];
  logic [DESC_W-1:0] slot_desc [WINDOW_SLOTS];

  packet_t   packets_to_send[$];
  ack_word_t ack_words_due[$];
  packet_t   bus_pkt;
  packet_t   pkt_next;
  ack_word_t got_word;
  ack_word_t want_word;

  logic [31:0] gen_next;
  int n_launched;
  int n_accepted;
  int n_directed;
  int n_results;
  int fail_count;
  int send_gap;
  int stall_left;
  int run_len;
  int longest_run;
  int status_seen [4];
  bit calm;
  bit full_window_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_ack(logic v, logic [15:0] h, logic [10:0] b, status_t st,
                                   logic last);
    ack_word_t w;
    w.rel_valid = v;
    w.handle    = h;
    w.bytes     = b;
    w.ack       = next_seq - 32'd1;
    w.status    = st;
    w.last      = last;
    ack_words_due.push_back(w);
  endfunction

  function automatic void predict_window_release(packet_t p);
    logic [31:0] span;
    logic [10:0] len;
    int slot;
    int n;
    span = p.seq - next_seq;
    slot = int'(p.seq % 32'(WINDOW_SLOTS));
    n = 0;
    if (p.stage == STAGE_FIN) begin
      push_ack(1'b0, '0, '0, ST_FIN, 1'b1);
    end else if (p.seq < next_seq) begin
      push_ack(1'b0, '0, '0, ST_DUP, 1'b1);
    end else if (span >= 32'(WINDOW_SLOTS)) begin
      push_ack(1'b0, '0, '0, ST_OUTWIN, 1'b1);
    end else if (slot_full[slot]) begin
      push_ack(1'b0, '0, '0, ST_DUP, 1'b1);
    end else begin
      len = (p.bytes > MAX_PAYLOAD) ? MAX_PAYLOAD : p.bytes;
      slot_desc[slot] = {p.handle, len};
      slot_full[slot] = 1'b1;
      if (p.seq != next_seq) begin
        push_ack(1'b0, '0, '0, ST_STORED, 1'b1);
      end else begin
        while (n < WINDOW_SLOTS) begin
          slot = int'(next_seq % 32'(WINDOW_SLOTS));
          if (!slot_full[slot]) break;
          slot_full[slot] = 1'b0;
          next_seq = next_seq + 32'd1;
          push_ack(1'b1, slot_desc[slot][26:11], slot_desc[slot][10:0], ST_STORED, 1'b0);
          n++;
        end
        ack_words_due[ack_words_due.size() - 1].last = 1'b1;
      end
    end
  endfunction

  task automatic add_pkt(logic [2:0] stage, logic [31:0] seq, logic [10:0] bytes,
                         logic [15:0] handle, bit hold);
    packet_t p;
    p.stage          = stage;
    p.seq            = seq;
    p.bytes          = bytes;
    p.handle         = handle;
    p.hold_for_drain = hold;
    packets_to_send.push_back(p);
  endtask

  function automatic logic [2:0] pick_data_stage();
    int s;
    s = $urandom_range(0, 6);
    if (s >= int'(STAGE_FIN)) s++;
    return 3'(s);
  endfunction

  function automatic logic [10:0] pick_bytes();
    if ($urandom_range(0, 7) == 0) return 11'($urandom_range(1461, 2047));
    return 11'($urandom_range(0, 1460));
  endfunction

  // stray word: finish, stale, or beyond the window
  task automatic add_noise();
    logic [31:0] s;
    s = $urandom;
    case ($urandom_range(0, 3))
      0: add_pkt(STAGE_FIN, s, pick_bytes(), 16'($urandom), 1'b0);
      1: begin
        if (gen_next != 0) s = $urandom_range(0, gen_next - 32'd1);
        add_pkt(pick_data_stage(), s, pick_bytes(), 16'($urandom), 1'b0);
      end
      2: begin
        if (s - gen_next < 32'(WINDOW_SLOTS)) s = gen_next + 32'(WINDOW_SLOTS) + s[5:0];
        add_pkt(pick_data_stage(), s, pick_bytes(), 16'($urandom), 1'b0);
      end
      default: add_pkt(pick_data_stage(), gen_next + 32'(WINDOW_SLOTS), pick_bytes(),
                       16'($urandom), 1'b0);
    endcase
  endtask

  // k consecutive sequence numbers, shuffled or descending, with noise and repeats
  task automatic add_block(int k, bit descending, bit hold_first);
    logic [31:0] ord [64];
    logic [31:0] t;
    int i;
    int j;
    for (i = 0; i < k; i++) ord[i] = descending ? gen_next + 32'(k - 1 - i) : gen_next + 32'(i);
    if (!descending) begin
      for (i = k - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = ord[i];
        ord[i] = ord[j];
        ord[j] = t;
      end
    end
    for (i = 0; i < k; i++) begin
      if ($urandom_range(0, 6) == 0) add_noise();
      add_pkt(pick_data_stage(), ord[i], pick_bytes(), 16'($urandom), hold_first && i == 0);
      if (i > 0 && $urandom_range(0, 9) == 0)
        add_pkt(pick_data_stage(), ord[$urandom_range(0, i - 1)], pick_bytes(),
                16'($urandom), 1'b0);
    end
    gen_next = gen_next + 32'(k);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // monitor: results checked first, then the accepted word is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_word.handle    = out_tdata[15:0];
        got_word.bytes     = out_tdata[26:16];
        got_word.ack       = out_tdata[58:27];
        got_word.rel_valid = out_tuser[0];
        got_word.status    = status_t'(out_tuser[2:1]);
        got_word.last      = out_tlast;
        n_results++;
        status_seen[out_tuser[2:1]]++;
        run_len++;
        if (out_tlast) begin
          if (run_len > longest_run) longest_run = run_len;
          run_len = 0;
        end
        if (ack_words_due.size() == 0) begin
          $error("result word with nothing expected: tdata %h tuser %h", out_tdata, out_tuser);
          fail_count++;
        end else begin
          want_word = ack_words_due.pop_front();
          check_field("release_valid", 32'(want_word.rel_valid), 32'(got_word.rel_valid));
          check_field("release_handle", 32'(want_word.handle), 32'(got_word.handle));
          check_field("release_bytes", 32'(want_word.bytes), 32'(got_word.bytes));
          check_field("ack_number", want_word.ack, got_word.ack);
          check_field("status_code", 32'(want_word.status), 32'(got_word.status));
          check_field("last_of_run", 32'(want_word.last), 32'(got_word.last));
        end
      end
      if (in_tvalid && in_tready) begin
        predict_window_release(bus_pkt);
        n_accepted++;
      end
    end
  end

  // driver and result-side backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      calm = packets_to_send.size() < 20;
      if (!in_tvalid || n_accepted == n_launched) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (packets_to_send.size() == 0 ||
                     (packets_to_send[0].hold_for_drain && ack_words_due.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 3);
          in_tvalid <= 1'b0;
        end else begin
          pkt_next = packets_to_send.pop_front();
          bus_pkt   <= pkt_next;
          in_tdata  <= {5'd0, pkt_next.handle, pkt_next.bytes, pkt_next.seq};
          in_tuser  <= pkt_next.stage;
          in_tvalid <= 1'b1;
          n_launched++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    next_seq = '0;
    for (int i = 0; i < WINDOW_SLOTS; i++) slot_full[i] = 1'b0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    n_launched = 0;
    n_accepted = 0;
    n_results = 0;
    fail_count = 0;
    send_gap = 0;
    stall_left = 0;
    run_len = 0;
    longest_run = 0;
    full_window_done = 1'b0;

    // directed: finish, stale, slot taken, window edge, saturation, multi-slot release
    add_pkt(STAGE_FIN, 32'd0, 11'd0, 16'h0000, 1'b0);
    add_pkt(3'd0, 32'd0, 11'd0, 16'h0000, 1'b0);
    add_pkt(3'd1, 32'd0, 11'd5, 16'h1234, 1'b0);
    add_pkt(3'd2, 32'd2, 11'd2047, 16'hFFFF, 1'b0);
    add_pkt(3'd3, 32'd2, 11'd10, 16'h0000, 1'b0);
    add_pkt(3'd5, 32'd64, 11'd100, 16'h0040, 1'b0);
    add_pkt(3'd6, 32'd65, 11'd200, 16'h0041, 1'b0);
    add_pkt(3'd7, 32'hFFFF_FFFF, 11'd2047, 16'hFFFF, 1'b0);
    add_pkt(STAGE_FIN, 32'hFFFF_FFFF, 11'd2047, 16'hFFFF, 1'b0);
    add_pkt(3'd0, 32'd3, 11'd1461, 16'h00FF, 1'b0);
    add_pkt(3'd2, 32'd1, 11'd1460, 16'h8001, 1'b0);
    add_pkt(3'd7, 32'h5555_5555, 11'h555, 16'h5555, 1'b0);
    add_pkt(3'd6, 32'hAAAA_AAAA, 11'h2AA, 16'hAAAA, 1'b0);
    add_pkt(3'd3, 32'd5, 11'd1, 16'h0002, 1'b0);
    add_pkt(3'd5, 32'd4, 11'd7, 16'h0003, 1'b1);
    add_pkt(3'd1, 32'd6, 11'd0, 16'hFFFF, 1'b0);
    add_pkt(STAGE_FIN, 32'd7, 11'd0, 16'h0000, 1'b0);
    n_directed = packets_to_send.size();
    gen_next = 32'd7;

    while (packets_to_send.size() < 110) begin
      if (!full_window_done && packets_to_send.size() > n_directed + 20) begin
        add_block(WINDOW_SLOTS, 1'b1, 1'b1);
        full_window_done = 1'b1;
      end else begin
        add_block($urandom_range(1, 8), 1'b0, $urandom_range(0, 9) == 0);
      end
    end

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    wait (packets_to_send.size() == 0 && n_accepted == n_launched);
    wait (ack_words_due.size() == 0);
    repeat (100) @(posedge clk);

    $display("Sent %0d packet words (%0d directed), checked %0d result words, longest run %0d.",
             n_launched, n_directed, n_results, longest_run);
    $display("Status mix: stored %0d, duplicate %0d, out of window %0d, finish %0d.",
             status_seen[ST_STORED], status_seen[ST_DUP], status_seen[ST_OUTWIN],
             status_seen[ST_FIN]);
    if (fail_count == 0 && ack_words_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d words still expected", ack_words_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rwr_pkg.sv
design/rwr_ctrl.sv
design/rwr_datapath.sv
design/reorder_window_receiver_unit.sv
test/tb_reorder_window_receiver_unit.sv
